### rtl/jdwa_pkg.sv
// ----------------------------------------------------------------------------
// jdwa_pkg: shared types and constants of the job dispatcher
// Item and result beat layouts, status and mode codes, register indexes,
// controller states and the saturating counter helper.
// ----------------------------------------------------------------------------
package jdwa_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS_IN_USE = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] PENDING_LIMIT_RST  = 16'd1024;
  localparam logic [4:0]  WORKERS_IN_USE_RST = 5'd16;

  // Item mode codes.
  localparam logic MODE_SUBMIT   = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef enum logic [2:0] {
    STAT_ACCEPT = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_ZERO   = 3'd2,
    STAT_DONE   = 3'd3,
    STAT_UNDER  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_NORM,
    ST_SCAN,
    ST_SUB_WR,
    ST_CMP_WR
  } state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] job_count;
    logic [3:0] done_worker;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  worker_index;
    logic [15:0] pending_total;
    logic [15:0] worker_depth;
    logic [31:0] submitted_total;
    logic [31:0] completed_total;
    logic [31:0] rejected_total;
    logic [15:0] max_depth_seen;
  } result_t;

  // Adds a job count to a statistics counter, sticking at all ones.
  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/jdwa_ram.sv
// ----------------------------------------------------------------------------
// jdwa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module jdwa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/jdwa_depth_store.sv
// ----------------------------------------------------------------------------
// jdwa_depth_store: per-worker queue depth memory
// Wraps the depth RAM with one valid bit per worker so that reset clears all
// depths at once; an entry never written reads as zero.
// ----------------------------------------------------------------------------
module jdwa_depth_store #(
  parameter int unsigned N_ENTRIES = 16,
  parameter int unsigned AW        = (N_ENTRIES > 1) ? $clog2(N_ENTRIES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [N_ENTRIES-1:0] valid_q;
  logic                 rvalid_q;
  logic [15:0]          ram_rdata;

  jdwa_ram #(
    .WIDTH(16),
    .DEPTH(N_ENTRIES),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .re_i   (re_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? ram_rdata : 16'd0;

endmodule

### rtl/jdwa_ctrl.sv
// ----------------------------------------------------------------------------
// jdwa_ctrl: dispatch controller
// Admission check, round-robin start, sequential least-depth scan over the
// depth memory, read-modify-write of the chosen depth and the statistics.
// ----------------------------------------------------------------------------
module jdwa_ctrl #(
  parameter int unsigned NUM_WORKERS = 16,
  parameter int unsigned MAX_BATCH   = 255,
  parameter int unsigned WW          = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  jdwa_pkg::item_t   item_i,
  input  logic [15:0]       pending_limit_i,
  input  logic [4:0]        workers_in_use_i,
  output logic              mem_re_o,
  output logic [WW-1:0]     mem_raddr_o,
  output logic              mem_we_o,
  output logic [WW-1:0]     mem_waddr_o,
  output logic [15:0]       mem_wdata_o,
  input  logic [15:0]       mem_rdata_i,
  output logic              result_valid_o,
  output jdwa_pkg::result_t result_o
);

  import jdwa_pkg::*;

  localparam int unsigned CW = $clog2(NUM_WORKERS + 1);

  state_e        state_q, state_d;
  logic [WW-1:0] rr_q, rr_d;
  logic [15:0]   pending_q, pending_d;
  logic [31:0]   submitted_q, submitted_d;
  logic [31:0]   completed_q, completed_d;
  logic [31:0]   rejected_q, rejected_d;
  logic [15:0]   peak_q, peak_d;
  logic          res_vld_q, res_vld_d;

  item_t         item_q, item_d;
  logic [CW-1:0] actw_q, actw_d;
  logic [WW-1:0] start_q, start_d;
  logic [WW-1:0] rd_idx_q, rd_idx_d;
  logic [WW-1:0] rsp_idx_q, rsp_idx_d;
  logic [CW-1:0] recv_q, recv_d;
  logic [15:0]   best_q, best_d;
  logic [WW-1:0] sel_q, sel_d;
  result_t       res_q, res_d;

  logic [7:0]    w8, act8;
  logic [15:0]   cnt16, headroom, new_depth;
  logic          over_batch, reject, dw_oob, zero_cnt, norm_done;
  logic          take, scan_done;
  logic [15:0]   best_n;
  logic [CW-1:0] recv_n;
  logic [WW-1:0] dw_idx;

  // Next index in the ring of active workers.
  function automatic logic [WW-1:0] ring_inc(logic [WW-1:0] x, logic [CW-1:0] w);
    logic [WW-1:0] r;
    r = x + WW'(1);
    if (CW'(x) + CW'(1) == w) begin
      r = '0;
    end
    return r;
  endfunction

  assign w8   = {3'd0, workers_in_use_i};
  assign act8 = (w8 == 8'd0) ? 8'd1 :
                (w8 > 8'(NUM_WORKERS)) ? 8'(NUM_WORKERS) : w8;

  assign cnt16      = {8'd0, item_q.job_count};
  assign zero_cnt   = (item_q.job_count == 8'd0);
  assign over_batch = (cnt16 > 16'(MAX_BATCH));
  assign headroom   = pending_limit_i - pending_q;
  assign reject     = over_batch || (pending_q > pending_limit_i) || (cnt16 > headroom);
  assign dw_oob     = ({4'd0, item_q.done_worker} >= 8'(NUM_WORKERS));
  assign dw_idx     = WW'(item_q.done_worker);
  assign norm_done  = (CW'(start_q) < actw_q);

  // Scan compare: the first candidate always wins, later ones only if shorter.
  assign take      = (recv_q == '0) || (mem_rdata_i < best_q);
  assign best_n    = take ? mem_rdata_i : best_q;
  assign recv_n    = recv_q + CW'(1);
  assign scan_done = (recv_n == actw_q) || (best_n == 16'd0);
  assign new_depth = (best_q == 16'hFFFF) ? best_q : best_q + 16'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (zero_cnt) begin
          state_d = ST_IDLE;
        end else if (item_q.mode == MODE_SUBMIT) begin
          state_d = reject ? ST_IDLE : ST_NORM;
        end else begin
          state_d = dw_oob ? ST_IDLE : ST_CMP_WR;
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_SUB_WR;
        end
      end
      ST_SUB_WR: state_d = ST_IDLE;
      ST_CMP_WR: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rr_d        = rr_q;
    pending_d   = pending_q;
    submitted_d = submitted_q;
    completed_d = completed_q;
    rejected_d  = rejected_q;
    peak_d      = peak_q;
    res_vld_d   = 1'b0;
    item_d      = item_q;
    actw_d      = actw_q;
    start_d     = start_q;
    rd_idx_d    = rd_idx_q;
    rsp_idx_d   = rsp_idx_q;
    recv_d      = recv_q;
    best_d      = best_q;
    sel_d       = sel_q;
    res_d       = res_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = sel_q;
    mem_wdata_o = new_depth;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          actw_d = CW'(act8);
        end
      end
      ST_DECIDE: begin
        if (zero_cnt) begin
          res_vld_d          = 1'b1;
          res_d.status       = STAT_ZERO;
          res_d.worker_index = 4'd0;
          res_d.worker_depth = 16'd0;
        end else if (item_q.mode == MODE_SUBMIT) begin
          if (reject) begin
            rejected_d         = sat_add32(rejected_q, item_q.job_count);
            res_vld_d          = 1'b1;
            res_d.status       = STAT_FULL;
            res_d.worker_index = 4'd0;
            res_d.worker_depth = 16'd0;
          end else begin
            start_d = rr_q;
          end
        end else if (dw_oob) begin
          res_vld_d          = 1'b1;
          res_d.status       = STAT_UNDER;
          res_d.worker_index = item_q.done_worker;
          res_d.worker_depth = 16'd0;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = dw_idx;
        end
      end
      ST_NORM: begin
        // The stored pointer is reduced below the active count one step a cycle.
        if (!norm_done) begin
          start_d = start_q - WW'(actw_q);
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = start_q;
          rsp_idx_d   = start_q;
          rd_idx_d    = ring_inc(start_q, actw_q);
          recv_d      = '0;
        end
      end
      ST_SCAN: begin
        best_d = best_n;
        sel_d  = take ? rsp_idx_q : sel_q;
        recv_d = recv_n;
        if (!scan_done) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_idx_q;
          rsp_idx_d   = rd_idx_q;
          rd_idx_d    = ring_inc(rd_idx_q, actw_q);
        end
      end
      ST_SUB_WR: begin
        mem_we_o           = 1'b1;
        mem_waddr_o        = sel_q;
        mem_wdata_o        = new_depth;
        pending_d          = pending_q + cnt16;
        peak_d             = (new_depth > peak_q) ? new_depth : peak_q;
        submitted_d        = sat_add32(submitted_q, item_q.job_count);
        rr_d               = ring_inc(start_q, actw_q);
        res_vld_d          = 1'b1;
        res_d.status       = STAT_ACCEPT;
        res_d.worker_index = 4'(sel_q);
        res_d.worker_depth = new_depth;
      end
      ST_CMP_WR: begin
        res_vld_d          = 1'b1;
        res_d.worker_index = item_q.done_worker;
        if ((mem_rdata_i == 16'd0) || (pending_q < cnt16) || over_batch) begin
          res_d.status       = STAT_UNDER;
          res_d.worker_depth = mem_rdata_i;
        end else begin
          mem_we_o           = 1'b1;
          mem_waddr_o        = dw_idx;
          mem_wdata_o        = mem_rdata_i - 16'd1;
          pending_d          = pending_q - cnt16;
          completed_d        = sat_add32(completed_q, item_q.job_count);
          res_d.status       = STAT_DONE;
          res_d.worker_depth = mem_rdata_i - 16'd1;
        end
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase

    if (res_vld_d) begin
      res_d.pending_total   = pending_d;
      res_d.submitted_total = submitted_d;
      res_d.completed_total = completed_d;
      res_d.rejected_total  = rejected_d;
      res_d.max_depth_seen  = peak_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rr_q        <= '0;
      pending_q   <= '0;
      submitted_q <= '0;
      completed_q <= '0;
      rejected_q  <= '0;
      peak_q      <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rr_q        <= rr_d;
      pending_q   <= pending_d;
      submitted_q <= submitted_d;
      completed_q <= completed_d;
      rejected_q  <= rejected_d;
      peak_q      <= peak_d;
      res_vld_q   <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    actw_q    <= actw_d;
    start_q   <= start_d;
    rd_idx_q  <= rd_idx_d;
    rsp_idx_q <= rsp_idx_d;
    recv_q    <= recv_d;
    best_q    <= best_d;
    sel_q     <= sel_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

### rtl/job_dispatcher_with_admission_core.sv
// ----------------------------------------------------------------------------
// job_dispatcher_with_admission_core: job dispatcher with admission limit
// Admits submitted jobs against a global pending limit, places each on the
// least loaded worker from a round-robin start, and releases completions.
// ----------------------------------------------------------------------------
//
// Results are strobed on result_valid_o for exactly one cycle and cannot be
// held off, so the receiver must take every result beat when it appears. An
// item is taken when start is high and busy is low; busy stays high until the
// result is produced, and a new item may be started in the cycle its result
// is strobed. A zero count, a rejected submit and a completion naming a
// worker index of NUM_WORKERS or more are each answered from the decide
// state without a memory access. A valid completion does one memory read
// and one write back of that worker's depth. An accepted submit examines
// up to the number of workers in use before its write back; the scan
// reads one depth per cycle from the single read port of the depth memory
// and stops early at an empty queue. When workers_in_use has been lowered
// to or below the stored round-robin pointer, the first submit after that
// subtracts the active count from the pointer until it is back in range.
// Depths live in a memory with one valid bit per worker, so reset takes
// effect at once and no clearing pass is needed.
//
// Configuration writes are always ready and must only be issued while busy
// is low. Register 0 is the pending limit, register 1 the number of workers
// that take part in dispatch (zero acts as one, values above NUM_WORKERS act
// as NUM_WORKERS). The worker index in the result beat is four bits wide.
//
module job_dispatcher_with_admission_core #(
  parameter int unsigned NUM_WORKERS = 16,
  parameter int unsigned MAX_BATCH   = 255
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  jdwa_pkg::item_t                      item_i,
  output logic                                 result_valid_o,
  output jdwa_pkg::result_t                    result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [jdwa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [jdwa_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import jdwa_pkg::*;

  localparam int unsigned WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

  logic [15:0]   pending_limit_q;
  logic [4:0]    workers_in_use_q;

  logic          mem_re, mem_we;
  logic [WW-1:0] mem_raddr, mem_waddr;
  logic [15:0]   mem_wdata, mem_rdata;

  // The configuration channel never stalls; writes beyond the register list
  // are accepted and dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_limit_q  <= PENDING_LIMIT_RST;
      workers_in_use_q <= WORKERS_IN_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PENDING_LIMIT:  pending_limit_q  <= cfg_data_i[15:0];
        CFG_WORKERS_IN_USE: workers_in_use_q <= cfg_data_i[4:0];
        default: begin
          pending_limit_q <= pending_limit_q;
        end
      endcase
    end
  end

  // Controller: admission, pointer normalization, depth scan and write back.
  jdwa_ctrl #(
    .NUM_WORKERS(NUM_WORKERS),
    .MAX_BATCH  (MAX_BATCH),
    .WW         (WW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .pending_limit_i (pending_limit_q),
    .workers_in_use_i(workers_in_use_q),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o)
  );

  // Per-worker queue depths; a worker never written since reset reads zero.
  jdwa_depth_store #(
    .N_ENTRIES(NUM_WORKERS),
    .AW       (WW)
  ) u_depths (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
